>>> design/dpfc_pkg.sv
`timescale 1ns / 1ps
package dpfc_pkg;

  // Sizing
  localparam int SIEVE_LIMIT = 16384;
  localparam int PRIME_SLOTS = 2048;
  localparam int VALUE_W     = 28;
  localparam int COUNT_W     = 4;
  localparam int MAP_AW      = $clog2(SIEVE_LIMIT);
  localparam int PRIME_W     = MAP_AW;
  localparam int SQ_W        = 2 * PRIME_W;
  localparam int CMP_W       = (SQ_W > VALUE_W) ? SQ_W : VALUE_W;
  localparam int SLOT_AW     = $clog2(PRIME_SLOTS);
  localparam int TOTAL_W     = $clog2(PRIME_SLOTS + 1);
  localparam int CNT_W       = MAP_AW + 1;

  // Divider: radix-2 steps folded per cycle
  localparam int DIV_STEP    = 4;
  localparam int DIV_ITERS   = (VALUE_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_CW      = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Prime table write from the sieve
  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    logic [PRIME_W-1:0] data;
  } tbl_wr_t;

  // Sieve status
  typedef struct packed {
    logic               done;
    logic [TOTAL_W-1:0] total;
  } sieve_stat_t;

  // Divider request / response
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [PRIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic               rem_zero;
  } div_rsp_t;

endpackage

>>> design/dpfc_if.sv
`timescale 1ns / 1ps
interface dpfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpfc_pkg::VALUE_W-1:0]  value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dpfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpfc_pkg::COUNT_W-1:0]  factor_count;
  modport source (output valid, output factor_count, input ready);
  modport sink   (input valid, input factor_count, output ready);
endinterface

>>> design/distinct_prime_factor_counter_top.sv
`timescale 1ns / 1ps
// Per stored prime tried: table read, load, square, compare, and a divide, then repeated
// divisions while that prime still divides the value; a failing square test, or the last
// stored prime, ends the search. One value at a time; next value accepted while a result
// waits. Reset: synchronous, active low. After reset a map clear and the sieve run before
// the first value is accepted.
module distinct_prime_factor_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  dpfc_in_if.sink     in_ch,
  dpfc_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_LOAD, S_SQ, S_TEST, S_DIV, S_FIN
  } state_t;

  state_t                          state_r;
  logic [dpfc_pkg::VALUE_W-1:0]    v_r;
  logic [dpfc_pkg::PRIME_W-1:0]    p_r;
  logic [dpfc_pkg::SQ_W-1:0]       sq_r;
  logic [dpfc_pkg::TOTAL_W-1:0]    idx_r;
  logic [dpfc_pkg::COUNT_W-1:0]    count_r;
  logic                            hit_r;
  logic                            out_valid_r;
  logic [dpfc_pkg::COUNT_W-1:0]    out_count_r;

  dpfc_pkg::tbl_wr_t     tbl_wr;
  dpfc_pkg::sieve_stat_t stat;
  dpfc_pkg::div_req_t    div_req;
  dpfc_pkg::div_rsp_t    div_rsp;
  logic [dpfc_pkg::PRIME_W-1:0] tbl_rdata;
  logic                          in_fire;
  logic [dpfc_pkg::COUNT_W-1:0] count_fin;

  dpfc_sieve u_sieve (
    .clk    (clk),
    .rst_n  (rst_n),
    .tbl_wr (tbl_wr),
    .stat   (stat)
  );

  dpfc_ram #(.WIDTH(dpfc_pkg::PRIME_W), .DEPTH(dpfc_pkg::PRIME_SLOTS)) u_table (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (idx_r[dpfc_pkg::SLOT_AW-1:0]),
    .rdata (tbl_rdata)
  );

  dpfc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Divider launch: first divide after the square test, repeats while divisible
  always_comb begin
    div_req.divisor  = p_r;
    div_req.dividend = (state_r == S_DIV) ? div_rsp.quot : v_r;
    div_req.start    = ((state_r == S_TEST) &&
                        (dpfc_pkg::CMP_W'(sq_r) <= dpfc_pkg::CMP_W'(v_r))) ||
                       ((state_r == S_DIV) && div_rsp.done && div_rsp.rem_zero);
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.factor_count = out_count_r;
  assign count_fin = ((v_r > dpfc_pkg::VALUE_W'(1)) && (count_r != dpfc_pkg::COUNT_MAX)) ?
                     count_r + 1'b1 : count_r;

  // Trial division sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      count_r     <= '0;
      hit_r       <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_ch.valid && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (stat.done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            v_r     <= in_ch.value;
            idx_r   <= '0;
            count_r <= '0;
            hit_r   <= 1'b0;
            state_r <= (stat.total == '0) ? S_FIN : S_READ;
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: begin
          p_r     <= tbl_rdata;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= {{dpfc_pkg::PRIME_W{1'b0}}, p_r} * {{dpfc_pkg::PRIME_W{1'b0}}, p_r};
          state_r <= S_TEST;
        end
        S_TEST: begin
          state_r <= div_req.start ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.rem_zero) begin
              v_r <= div_rsp.quot;
              if (!hit_r && (count_r != dpfc_pkg::COUNT_MAX)) begin
                count_r <= count_r + 1'b1;
              end
              hit_r <= 1'b1;
            end else begin
              hit_r <= 1'b0;
              if (idx_r + 1'b1 == stat.total) begin
                state_r <= S_FIN;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_READ;
              end
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_fin;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  // Checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (idx_r < stat.total))
    else $error("prime table read beyond stored primes");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= dpfc_pkg::COUNT_W'(9)))
    else $error("factor count out of range");

  a_no_accept_before_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> stat.done)
    else $error("transaction accepted before sieve finished");

endmodule

>>> design/dpfc_ram.sv
`timescale 1ns / 1ps
module dpfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dpfc_sieve.sv
`timescale 1ns / 1ps
module dpfc_sieve (
  input  logic                  clk,
  input  logic                  rst_n,
  output dpfc_pkg::tbl_wr_t     tbl_wr,
  output dpfc_pkg::sieve_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLR, S_ISQ, S_ICHK, S_IRD, S_MARK, S_SCAN, S_DRAIN, S_DONE
  } state_t;

  localparam int AW = dpfc_pkg::MAP_AW;
  localparam int CW = dpfc_pkg::CNT_W;
  localparam logic [CW-1:0] LIMIT = CW'(dpfc_pkg::SIEVE_LIMIT);

  state_t                         state_r;
  logic [CW-1:0]                  c_r;      // clear / scan counter
  logic [AW-1:0]                  i_r;      // sieving prime candidate
  logic [CW-1:0]                  j_r;      // multiple being marked
  logic [dpfc_pkg::SQ_W-1:0]      sq_r;
  logic                           scan_v_r;
  logic [AW-1:0]                  scan_k_r;
  logic [dpfc_pkg::TOTAL_W-1:0]   total_r;

  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic [AW-1:0] map_raddr;
  logic          map_rdata;
  logic [CW-1:0] j_step;

  assign j_step = j_r + CW'(i_r);

  // Map port muxing
  always_comb begin
    map_we    = 1'b0;
    map_waddr = c_r[AW-1:0];
    map_wdata = 1'b0;
    map_raddr = c_r[AW-1:0];
    unique case (state_r)
      S_CLR: begin
        map_we = 1'b1;
      end
      S_MARK: begin
        map_we    = 1'b1;
        map_waddr = j_r[AW-1:0];
        map_wdata = 1'b1;
      end
      S_ICHK: begin
        map_raddr = i_r;
      end
      default: ;
    endcase
  end

  dpfc_ram #(.WIDTH(1), .DEPTH(dpfc_pkg::SIEVE_LIMIT)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // A prime table write, for an unmarked entry while slots remain, comes in the cycle after its scan read
  always_comb begin
    tbl_wr.en   = scan_v_r && !map_rdata &&
                  (total_r < dpfc_pkg::TOTAL_W'(dpfc_pkg::PRIME_SLOTS));
    tbl_wr.addr = total_r[dpfc_pkg::SLOT_AW-1:0];
    tbl_wr.data = scan_k_r;
  end

  assign stat.done  = (state_r == S_DONE);
  assign stat.total = total_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      c_r      <= '0;
      i_r      <= AW'(2);
      scan_v_r <= 1'b0;
      total_r  <= '0;
    end else begin
      scan_v_r <= (state_r == S_SCAN);
      scan_k_r <= c_r[AW-1:0];
      if (tbl_wr.en) begin
        total_r <= total_r + 1'b1;
      end
      unique case (state_r)
        S_CLR: begin
          if (c_r == LIMIT - 1'b1) begin
            state_r <= S_ISQ;
          end
          c_r <= c_r + 1'b1;
        end
        S_ISQ: begin
          sq_r    <= {{AW{1'b0}}, i_r} * {{AW{1'b0}}, i_r};
          state_r <= S_ICHK;
        end
        S_ICHK: begin
          if (sq_r >= dpfc_pkg::SQ_W'(LIMIT)) begin
            c_r     <= CW'(2);
            state_r <= S_SCAN;
          end else begin
            state_r <= S_IRD;
          end
        end
        S_IRD: begin
          if (map_rdata) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ISQ;
          end else begin
            j_r     <= CW'(sq_r);
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          j_r <= j_step;
          if (j_step >= LIMIT) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ISQ;
          end
        end
        S_SCAN: begin
          c_r <= c_r + 1'b1;
          if (c_r == LIMIT - 1'b1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: ;
        default: state_r <= S_CLR;
      endcase
    end
  end

endmodule

>>> design/dpfc_div.sv
`timescale 1ns / 1ps
module dpfc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dpfc_pkg::div_req_t req,
  output dpfc_pkg::div_rsp_t rsp
);

  localparam int VW = dpfc_pkg::VALUE_W;
  localparam int DW = dpfc_pkg::PRIME_W;

  logic                      busy_r;
  logic                      done_r;
  logic [dpfc_pkg::DIV_CW-1:0] cnt_r;
  logic [DW:0]               rem_r;
  logic [VW-1:0]             quo_r;
  logic [DW-1:0]             dvs_r;
  logic [DW:0]               rem_nxt;
  logic [VW-1:0]             quo_nxt;

  // Several restoring steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int s = 0; s < dpfc_pkg::DIV_STEP; s++) begin
      rem_nxt = {rem_nxt[DW-1:0], quo_nxt[VW-1]};
      quo_nxt = {quo_nxt[VW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == dpfc_pkg::DIV_CW'(dpfc_pkg::DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quot     = quo_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

>>> verif/tb_distinct_prime_factor_counter_top.sv
`timescale 1ns / 1ps
module tb_distinct_prime_factor_counter_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpfc_in_if  in_ch();
  dpfc_out_if out_ch();

  distinct_prime_factor_counter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the prime table
  int unsigned primes[$];
  logic [dpfc_pkg::COUNT_W-1:0] count_q[$];
  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  bit rx_hold = 1'b0;
  bit calm = 1'b0;

  // directed table: value and, where obvious, expected count (-1: use predictor)
  typedef struct {
    logic [dpfc_pkg::VALUE_W-1:0] value;
    int                           expected;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic void build_primes();
    bit comp[];
    comp = new[dpfc_pkg::SIEVE_LIMIT];
    for (int i = 2; i * i < dpfc_pkg::SIEVE_LIMIT; i++)
      if (!comp[i])
        for (int j = i * i; j < dpfc_pkg::SIEVE_LIMIT; j += i) comp[j] = 1'b1;
    for (int i = 2; i < dpfc_pkg::SIEVE_LIMIT; i++)
      if (!comp[i] && primes.size() < dpfc_pkg::PRIME_SLOTS) primes.push_back(i);
  endfunction

  function automatic logic [dpfc_pkg::COUNT_W-1:0] distinct_factors(
    logic [dpfc_pkg::VALUE_W-1:0] value);
    longint unsigned v;
    int unsigned cnt;
    v = value;
    cnt = 0;
    if (v < 2) return '0;
    foreach (primes[k]) begin
      if (longint'(primes[k]) * primes[k] > v) break;
      if (v % primes[k] == 0) begin
        if (cnt < dpfc_pkg::COUNT_MAX) cnt++;
        while (v % primes[k] == 0) v = v / primes[k];
      end
    end
    if (v > 1 && cnt < dpfc_pkg::COUNT_MAX) cnt++;
    return cnt[dpfc_pkg::COUNT_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // drop the input between transactions
  task automatic idle_input();
    in_ch.valid <= 1'b0;
    in_ch.value <= dpfc_pkg::VALUE_W'($urandom);
  endtask

  // push one transaction; waits for acceptance
  task automatic send_value(logic [dpfc_pkg::VALUE_W-1:0] value, int expected);
    logic [dpfc_pkg::COUNT_W-1:0] pred;
    pred = distinct_factors(value);
    if (expected >= 0 && pred != expected[dpfc_pkg::COUNT_W-1:0])
      report_mismatch($sformatf("predictor table row value %0d", value));
    while (!calm && $urandom_range(99) < 21) begin
      idle_input();
      @(posedge clk);
    end
    count_q.push_back(pred);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [dpfc_pkg::VALUE_W-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return dpfc_pkg::VALUE_W'($urandom_range(15));
      1: return dpfc_pkg::VALUE_W'(primes[$urandom_range(primes.size() - 1)]);
      2: return dpfc_pkg::VALUE_W'(longint'(primes[$urandom_range(40)]) *
                                   primes[$urandom_range(primes.size() - 1)]);
      3: return dpfc_pkg::VALUE_W'(30030 * $urandom_range(8000));
      4: return dpfc_pkg::VALUE_W'(1 << $urandom_range(dpfc_pkg::VALUE_W - 1));
      5: return dpfc_pkg::VALUE_W'($urandom_range(16383));
      default: return dpfc_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // result side: random stalls plus forced hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (count_q.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", out_ch.factor_count));
        else begin
          if (out_ch.factor_count !== count_q[0])
            report_mismatch($sformatf("factor_count got %0d want %0d",
                                      out_ch.factor_count, count_q[0]));
          void'(count_q.pop_front());
        end
      end
      out_ch.ready <= !rx_hold && (calm || $urandom_range(99) >= 21);
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (sent == 30);
    rx_hold <= 1'b1;
    repeat (50000) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #1_000_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    build_primes();
    // extremes, zero and one, table boundaries, maximal counts
    directed.push_back('{28'd0, 0});
    directed.push_back('{28'd1, 0});
    directed.push_back('{28'd2, 1});
    directed.push_back('{28'd3, 1});
    directed.push_back('{28'd4, 1});
    directed.push_back('{28'd6, 2});
    directed.push_back('{28'd30030, 6});
    directed.push_back('{28'd9699690, 8});
    directed.push_back('{28'd223092870, 9});
    directed.push_back('{28'hFFFFFFF, -1});
    directed.push_back('{28'd16381, 1});
    directed.push_back('{28'd16383, -1});
    directed.push_back('{28'd268435399, 1});
    directed.push_back('{28'd268337161, 1});
    directed.push_back('{28'd134217728, 1});
    directed.push_back('{28'd268435454, -1});
    directed.push_back('{28'hAAAAAAA, -1});
    directed.push_back('{28'h5555555, -1});
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[r]) send_value(directed[r].value, directed[r].expected);
    for (int n = 0; n < 132; n++) begin
      if (n == 50) begin
        // sender pause until drained
        idle_input();
        while (count_q.size() != 0) @(posedge clk);
      end
      calm = (n >= 80 && n < 110);
      send_value(rand_value(), -1);
    end
    calm = 1'b0;
    idle_input();
    while (count_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d values (zero/one, primes, semiprimes, primorials, powers of two)",
             sent);
    $display("Collected %0d factor counts, with long output hold-off", results_seen);
    if (errors == 0 && count_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
